FILE: hdl/context_time_accounting_defines.svh
// ----------------------------------------------------------------------------
// context_time_accounting_defines
// assertion macros shared by the accounting block
// ----------------------------------------------------------------------------
`ifndef CONTEXT_TIME_ACCOUNTING_DEFINES_SVH
`define CONTEXT_TIME_ACCOUNTING_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CTA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CTA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// invariant on every clock edge outside reset
`define CTA_ASSERT_ALW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

FILE: hdl/cta_pkg.sv
// ----------------------------------------------------------------------------
// cta_pkg
// shared types and constants of the context time accounting block
// ----------------------------------------------------------------------------
package cta_pkg;

	// nanoseconds per microsecond
	localparam int unsigned NS_PER_UNIT = 1000;

	// input command codes
	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_SWITCH = 3'd1,
		CMD_READ   = 3'd2,
		CMD_DELTA  = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_code_t;

	// which result the output register takes
	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_PREV  = 2'd1,
		RES_READ  = 2'd2,
		RES_DELTA = 2'd3
	} res_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic     clr_step;
		logic     in_load;
		logic     cpu_wr;
		logic     tmr_rd_old;
		logic     div_load;
		logic     div_step;
		logic     mul_load;
		logic     tmr_wr_zero;
		logic     tmr_wr_charge;
		logic     res_load;
		res_sel_t res_sel;
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       clr_last;
		logic       div_last;
		logic       out_free;
	} sts_t;

endpackage

FILE: hdl/cta_ctrl.sv
// ----------------------------------------------------------------------------
// cta_ctrl
// sequencer for clearing, command fetch, charge division, delta product and result hand-off
// ----------------------------------------------------------------------------
module cta_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output cta_pkg::ctl_t ctl,
	input  cta_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_DIV,
		ST_DONE,
		ST_DELTA
	} state_t;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and command decode
	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		ctl.res_sel = cta_pkg::RES_ZERO;
		in_ready    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				ctl.in_load = in_valid;
				if (in_valid) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				if (sts.op == cta_pkg::CMD_SWITCH) begin
					// running timer known: fetch its entry, retarget the cpu
					ctl.cpu_wr     = 1'b1;
					ctl.tmr_rd_old = 1'b1;
					state_d        = ST_LOAD;
				end else if (sts.op == cta_pkg::CMD_DELTA) begin
					ctl.mul_load = 1'b1;
					state_d      = ST_DELTA;
				end else if (sts.out_free) begin
					ctl.res_load = 1'b1;
					state_d      = ST_IDLE;
					case (sts.op)
						cta_pkg::CMD_START: begin
							ctl.cpu_wr  = 1'b1;
							ctl.res_sel = cta_pkg::RES_PREV;
						end
						cta_pkg::CMD_READ: begin
							ctl.res_sel = cta_pkg::RES_READ;
						end
						cta_pkg::CMD_CLEAR: begin
							ctl.tmr_wr_zero = 1'b1;
						end
						default: begin
							ctl.res_sel = cta_pkg::RES_ZERO;
						end
					endcase
				end
			end
			ST_LOAD: begin
				ctl.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.tmr_wr_charge = 1'b1;
					ctl.res_load      = 1'b1;
					ctl.res_sel       = cta_pkg::RES_PREV;
					state_d           = ST_IDLE;
				end
			end
			ST_DELTA: begin
				if (sts.out_free) begin
					ctl.res_load = 1'b1;
					ctl.res_sel  = cta_pkg::RES_DELTA;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

FILE: hdl/cta_datapath.sv
// ----------------------------------------------------------------------------
// cta_datapath
// timer and cpu memories, charge divider, delta multiplier, output register
// ----------------------------------------------------------------------------
module cta_datapath #(
	parameter int unsigned NUM_TIMERS       = 64,
	parameter int unsigned NUM_CPUS         = 4,
	parameter int unsigned UNITS_PER_SECOND = 1000000
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cta_pkg::ctl_t ctl,
	output cta_pkg::sts_t sts,
	input  logic [2:0]    cmd,
	input  logic [1:0]    cpu,
	input  logic [5:0]    timer_index,
	input  logic [31:0]   timestamp,
	input  logic [31:0]   saved_seconds,
	input  logic [31:0]   saved_micros,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [5:0]    previous_timer,
	output logic [31:0]   seconds,
	output logic [31:0]   microseconds,
	output logic [29:0]   nanoseconds,
	output logic [31:0]   delta_micros
);

	localparam int unsigned TIW   = $clog2(NUM_TIMERS);
	localparam int unsigned CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int unsigned CLR_N = (NUM_TIMERS > NUM_CPUS) ? NUM_TIMERS : NUM_CPUS;
	localparam int unsigned CLW   = $clog2(CLR_N);
	localparam int unsigned SW    = 34;
	localparam longint unsigned SUM_MAX = longint'(UNITS_PER_SECOND) - 1 + 64'hFFFF_FFFF;
	localparam longint unsigned Q_MAX   = SUM_MAX / UNITS_PER_SECOND;
	localparam int unsigned QW    = $clog2(Q_MAX + 1);
	// reciprocal of the units per second, scaled so that it fills 32 bits
	localparam int unsigned RCP_L = $clog2(UNITS_PER_SECOND);
	localparam int unsigned RCP_K = 31 + RCP_L;
	localparam logic [31:0] RCP_M = 32'((64'd1 << RCP_K) / UNITS_PER_SECOND);
	// divider steps: multiply, estimate, remainder, two corrections
	localparam int unsigned DIV_STEPS = 5;
	localparam int unsigned CNW   = $clog2(DIV_STEPS);
	localparam logic [CNW-1:0] PH_MUL = CNW'(4);
	localparam logic [CNW-1:0] PH_EST = CNW'(3);
	localparam logic [CNW-1:0] PH_REM = CNW'(2);

	// memories
	logic [TIW-1:0] cpu_run_mem   [NUM_CPUS];
	logic [31:0]    cpu_stamp_mem [NUM_CPUS];
	logic [31:0]    tmr_secs_mem  [NUM_TIMERS];
	logic [31:0]    tmr_usecs_mem [NUM_TIMERS];

	// index folding tables
	logic [CW-1:0]  cpu_mod [4];
	logic [TIW-1:0] tmr_mod [64];

	logic [CLW-1:0] clr_cnt_q;
	logic [31:0]    period_q;
	logic [2:0]     op_q;
	logic [CW-1:0]  cpu_q;
	logic [TIW-1:0] tix_q;
	logic [31:0]    ts_q;
	logic [31:0]    ssec_q;
	logic [31:0]    susec_q;
	logic [TIW-1:0] cpu_run_rd_q;
	logic [31:0]    cpu_stamp_rd_q;
	logic [31:0]    tmr_secs_rd_q;
	logic [31:0]    tmr_usecs_rd_q;
	logic [SW-1:0]  rem_q;
	logic [63:0]    rcp_q;
	logic [QW-1:0]  quo_q;
	logic [CNW-1:0] div_cnt_q;
	logic [31:0]    prod_q;
	logic           out_valid_q;
	logic [5:0]     prev_q;
	logic [31:0]    secs_q;
	logic [31:0]    usecs_q;
	logic [29:0]    nsecs_q;
	logic [31:0]    delta_q;

	logic           clr_tmr;
	logic           clr_cpu;
	logic           tmr_we;
	logic [TIW-1:0] tmr_waddr;
	logic [31:0]    tmr_wsecs;
	logic [31:0]    tmr_wusecs;
	logic           cpu_we;
	logic [CW-1:0]  cpu_waddr;
	logic [TIW-1:0] cpu_wrun;
	logic [31:0]    cpu_wstamp;
	logic [31:0]    diff;
	logic [31:0]    elapsed;
	logic [SW-1:0]  sum;
	logic           div_ge;

	for (genvar i = 0; i < 4; i++) begin : g_cpu_mod
		assign cpu_mod[i] = CW'(i % NUM_CPUS);
	end

	for (genvar i = 0; i < 64; i++) begin : g_tmr_mod
		assign tmr_mod[i] = TIW'(i % NUM_TIMERS);
	end

	// clearing sweep coverage
	assign clr_tmr = ctl.clr_step && ({1'b0, clr_cnt_q} < (CLW + 1)'(NUM_TIMERS));
	assign clr_cpu = ctl.clr_step && ({1'b0, clr_cnt_q} < (CLW + 1)'(NUM_CPUS));

	// timer memory write port
	always_comb begin
		tmr_we     = clr_tmr || ctl.tmr_wr_zero || ctl.tmr_wr_charge;
		tmr_waddr  = tix_q;
		tmr_wsecs  = '0;
		tmr_wusecs = '0;
		if (ctl.clr_step) begin
			tmr_waddr = clr_cnt_q[TIW-1:0];
		end else if (ctl.tmr_wr_charge) begin
			tmr_waddr  = cpu_run_rd_q;
			tmr_wsecs  = tmr_secs_rd_q + 32'(quo_q);
			tmr_wusecs = rem_q[31:0];
		end
	end

	// cpu memory write port
	always_comb begin
		cpu_we     = clr_cpu || ctl.cpu_wr;
		cpu_waddr  = cpu_q;
		cpu_wrun   = tix_q;
		cpu_wstamp = ts_q;
		if (ctl.clr_step) begin
			cpu_waddr  = clr_cnt_q[CW-1:0];
			cpu_wrun   = '0;
			cpu_wstamp = '0;
		end
	end

	// elapsed time with wrap period correction
	always_comb begin
		diff    = ts_q - cpu_stamp_rd_q;
		elapsed = (diff[31] && (period_q != 32'd0)) ? (diff + period_q) : diff;
		sum     = SW'(tmr_usecs_rd_q) + SW'(elapsed);
		div_ge  = (rem_q >= SW'(UNITS_PER_SECOND));
	end

	// memory arrays and registered reads
	always_ff @(posedge clk) begin
		if (tmr_we) begin
			tmr_secs_mem[tmr_waddr]  <= tmr_wsecs;
			tmr_usecs_mem[tmr_waddr] <= tmr_wusecs;
		end
		if (cpu_we) begin
			cpu_run_mem[cpu_waddr]   <= cpu_wrun;
			cpu_stamp_mem[cpu_waddr] <= cpu_wstamp;
		end
		if (ctl.in_load) begin
			cpu_run_rd_q   <= cpu_run_mem[cpu_mod[cpu]];
			cpu_stamp_rd_q <= cpu_stamp_mem[cpu_mod[cpu]];
			tmr_secs_rd_q  <= tmr_secs_mem[tmr_mod[timer_index]];
			tmr_usecs_rd_q <= tmr_usecs_mem[tmr_mod[timer_index]];
		end else if (ctl.tmr_rd_old) begin
			tmr_secs_rd_q  <= tmr_secs_mem[cpu_run_rd_q];
			tmr_usecs_rd_q <= tmr_usecs_mem[cpu_run_rd_q];
		end
	end

	// input capture, divider, multiplier and result payload
	always_ff @(posedge clk) begin
		if (ctl.in_load) begin
			op_q    <= cmd;
			cpu_q   <= cpu_mod[cpu];
			tix_q   <= tmr_mod[timer_index];
			ts_q    <= timestamp;
			ssec_q  <= saved_seconds;
			susec_q <= saved_micros;
		end
		// reciprocal estimate of the whole seconds, then remainder and fix-up
		if (ctl.div_load) begin
			rem_q <= sum;
			quo_q <= '0;
		end else if (ctl.div_step) begin
			case (div_cnt_q)
				PH_MUL: begin
					rcp_q <= 64'(rem_q[32:1]) * 64'(RCP_M);
				end
				PH_EST: begin
					quo_q <= QW'(rcp_q >> (RCP_K - 1));
				end
				PH_REM: begin
					rem_q <= rem_q - SW'(quo_q) * SW'(UNITS_PER_SECOND);
				end
				default: begin
					// estimate is at most two short
					if (div_ge) begin
						rem_q <= rem_q - SW'(UNITS_PER_SECOND);
						quo_q <= quo_q + QW'(1);
					end
				end
			endcase
		end
		if (ctl.mul_load) begin
			prod_q <= 32'((tmr_secs_rd_q - ssec_q) * 32'(UNITS_PER_SECOND));
		end
		if (ctl.res_load) begin
			prev_q  <= '0;
			secs_q  <= '0;
			usecs_q <= '0;
			nsecs_q <= '0;
			delta_q <= '0;
			case (ctl.res_sel)
				cta_pkg::RES_PREV: begin
					prev_q <= 6'(cpu_run_rd_q);
				end
				cta_pkg::RES_READ: begin
					secs_q  <= tmr_secs_rd_q;
					usecs_q <= tmr_usecs_rd_q;
					nsecs_q <= 30'(tmr_usecs_rd_q[29:0] * 30'(cta_pkg::NS_PER_UNIT));
				end
				cta_pkg::RES_DELTA: begin
					secs_q  <= tmr_secs_rd_q;
					usecs_q <= tmr_usecs_rd_q;
					delta_q <= prod_q + tmr_usecs_rd_q - susec_q;
				end
				default: begin
					prev_q <= '0;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			period_q    <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_step) clr_cnt_q <= clr_cnt_q + CLW'(1);
			if (cfg_we) period_q <= cfg_wdata;
			if (ctl.div_load) begin
				div_cnt_q <= CNW'(DIV_STEPS - 1);
			end else if (ctl.div_step) begin
				div_cnt_q <= div_cnt_q - CNW'(1);
			end
			if (ctl.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status back to the controller
	assign sts.op       = op_q;
	assign sts.clr_last = (clr_cnt_q == CLW'(CLR_N - 1));
	assign sts.div_last = (div_cnt_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign previous_timer = prev_q;
	assign seconds        = secs_q;
	assign microseconds   = usecs_q;
	assign nanoseconds    = nsecs_q;
	assign delta_micros   = delta_q;

endmodule

FILE: hdl/context_time_accounting.sv
// ----------------------------------------------------------------------------
// context_time_accounting
// per-cpu run-time accounting over a bank of seconds/microseconds timers
// ----------------------------------------------------------------------------
// usage
// - input channel in_valid/in_ready carries one command beat (start, switch,
//   read, delta, clear) with cpu, timer_index, timestamp and saved value
// - output channel out_valid/out_ready returns exactly one result beat per
//   command; cfg_we/cfg_wdata set the timestamp wrap period (zero: none)
// - after reset a clearing pass zeroes both memories over
//   max(NUM_TIMERS, NUM_CPUS) addresses; in_ready stays low until it finishes
// - one command is in work at a time: start, read, clear and unknown codes
//   finish in the fetch state, delta passes through the delta state, switch
//   through the load, divide and done states; the next beat is taken only
//   once the last one finishes
// - the switch charge splits off whole seconds with a reciprocal multiply,
//   a remainder step and two correction steps; the memories have
//   registered single-port reads
// - a registered result beat may wait on out_ready while the next command is
//   accepted; that command finishes once the output slot drains
// ----------------------------------------------------------------------------
`include "context_time_accounting_defines.svh"

module context_time_accounting #(
	parameter int unsigned NUM_TIMERS       = 64,
	parameter int unsigned NUM_CPUS         = 4,
	parameter int unsigned UNITS_PER_SECOND = 1000000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [1:0]  cpu,
	input  logic [5:0]  timer_index,
	input  logic [31:0] timestamp,
	input  logic [31:0] saved_seconds,
	input  logic [31:0] saved_micros,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  previous_timer,
	output logic [31:0] seconds,
	output logic [31:0] microseconds,
	output logic [29:0] nanoseconds,
	output logic [31:0] delta_micros
);

	cta_pkg::ctl_t ctl;
	cta_pkg::sts_t sts;

	// sequencer
	cta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// storage and arithmetic
	cta_datapath #(
		.NUM_TIMERS       (NUM_TIMERS),
		.NUM_CPUS         (NUM_CPUS),
		.UNITS_PER_SECOND (UNITS_PER_SECOND)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.cmd            (cmd),
		.cpu            (cpu),
		.timer_index    (timer_index),
		.timestamp      (timestamp),
		.saved_seconds  (saved_seconds),
		.saved_micros   (saved_micros),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.previous_timer (previous_timer),
		.seconds        (seconds),
		.microseconds   (microseconds),
		.nanoseconds    (nanoseconds),
		.delta_micros   (delta_micros)
	);

	// one command in work: accepting a beat closes the input
	`CTA_ASSERT_NXT(a_one_in_work, in_valid && in_ready, !in_ready, "accepted while busy")
	// a result is only loaded into a free output slot
	`CTA_ASSERT_IMP(a_res_slot, ctl.res_load, sts.out_free, "result overwrote pending beat")
	// the timer memory has a single write source per cycle
	`CTA_ASSERT_ALW(a_tmr_wr_src, $onehot0({ctl.clr_step, ctl.tmr_wr_zero, ctl.tmr_wr_charge}),
		"timer write conflict")
	// the divider never runs while a new command is taken
	`CTA_ASSERT_IMP(a_div_idle, in_ready, !ctl.div_step && !ctl.div_load, "divider busy at idle")

endmodule
